FILE: design/utf8lc_pkg.sv
// utf8lc_pkg: beat types, result group type, byte-class constants and the
// case-folding function used by the utf8 lowercase transcoder modules.
// depends on nothing
package utf8lc_pkg;

  localparam int unsigned MaxOut    = 4;  // most bytes one input beat can produce
  localparam int unsigned HeldDepth = 3;  // most bytes held for an open sequence

  // input beat: one raw byte of the string
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_beat_t;

  // output beat: one emitted byte or an end marker
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       run_end;
    logic       string_end;
  } out_beat_t;

  typedef logic [2:0]  cnt_t;  // 0..MaxOut
  typedef logic [1:0]  held_t; // 0..HeldDepth
  typedef logic [20:0] cp_t;   // code point as decoded from up to 4 bytes

  typedef logic [HeldDepth-1:0][7:0] held_bytes_t;
  typedef logic [MaxOut-1:0][7:0]    out_bytes_t;

  // all output beats caused by one input beat
  typedef struct packed {
    out_bytes_t bytes;   // byte 0 goes out first
    cnt_t       cnt;     // beats to send, 1..MaxOut
    logic       marker;  // single end marker, no byte
    logic       last;    // group closes the string
  } grp_t;

  // byte classes
  localparam logic [7:0] LeadMin  = 8'hC2;
  localparam logic [7:0] LeadMax  = 8'hF4;
  localparam logic [7:0] Lead3Min = 8'hE0;
  localparam logic [7:0] Lead4Min = 8'hF0;
  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag  = 8'h80;

  // encoder thresholds and lead tags
  localparam cp_t        Cp1Limit = 21'h000080;
  localparam cp_t        Cp2Limit = 21'h000800;
  localparam cp_t        Cp3Limit = 21'h010000;
  localparam cp_t        CpLimit  = 21'h110000;
  localparam logic [7:0] Tag2     = 8'hC0;
  localparam logic [7:0] Tag3     = 8'hE0;
  localparam logic [7:0] Tag4     = 8'hF0;

  // case folding
  localparam cp_t LatUpMin   = 21'h000041;
  localparam cp_t LatUpMax   = 21'h00005A;
  localparam cp_t CyrUpMin   = 21'h000410;
  localparam cp_t CyrUpMax   = 21'h00042F;
  localparam cp_t CyrIoUp    = 21'h000401;
  localparam cp_t CyrIoLow   = 21'h000451;
  localparam cp_t CaseOffset = 21'h000020;

  function automatic cp_t lower_cp(input cp_t cp);
    cp_t res;
    res = cp;
    if ((cp >= LatUpMin && cp <= LatUpMax) || (cp >= CyrUpMin && cp <= CyrUpMax)) begin
      res = cp + CaseOffset;
    end else if (cp == CyrIoUp) begin
      res = CyrIoLow;
    end
    return res;
  endfunction

endpackage

FILE: design/utf8lc_step.sv
// utf8lc_step: next-state and result-group logic for one input byte
// (decode, lowercase, shortest-form re-encode, raw flush of broken sequences)
// depends on utf8lc_pkg
module utf8lc_step (
  input  utf8lc_pkg::in_beat_t    beat,
  input  utf8lc_pkg::held_bytes_t held,
  input  utf8lc_pkg::held_t       held_cnt,
  output utf8lc_pkg::grp_t        grp,
  output logic                    grp_load,
  output utf8lc_pkg::held_bytes_t held_nxt,
  output utf8lc_pkg::held_t       held_cnt_nxt
);

  logic [7:0]             b;
  logic                   is_cont;
  logic                   is_lead;
  logic                   len3;
  logic                   len4;
  logic                   complete;
  utf8lc_pkg::cp_t        cp;
  utf8lc_pkg::cp_t        lcp;
  utf8lc_pkg::cp_t        asc_low;
  utf8lc_pkg::out_bytes_t enc;
  utf8lc_pkg::cnt_t       enc_n;
  logic                   use_enc;
  utf8lc_pkg::held_t      raw_h;
  logic [7:0]             tail;
  logic                   tail_en;
  utf8lc_pkg::cnt_t       cnt;

  assign b        = beat.in_byte;
  assign is_cont  = (b & utf8lc_pkg::ContMask) == utf8lc_pkg::ContTag;
  assign is_lead  = (b >= utf8lc_pkg::LeadMin) && (b <= utf8lc_pkg::LeadMax);
  assign len3     = held[0] >= utf8lc_pkg::Lead3Min;
  assign len4     = held[0] >= utf8lc_pkg::Lead4Min;
  // this continuation byte closes the sequence
  assign complete = !len3 || (!len4 && held_cnt >= 2'd2) || (held_cnt == 2'd3);
  assign asc_low  = utf8lc_pkg::lower_cp({13'd0, b});

  // decode
  always_comb begin
    if (len4) begin
      cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
    end else if (len3) begin
      cp = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
    end else begin
      cp = {10'd0, held[0][4:0], b[5:0]};
    end
  end

  assign lcp = utf8lc_pkg::lower_cp(cp);

  // shortest-form encode, nothing at or above the unicode limit
  always_comb begin
    enc = '0;
    if (lcp < utf8lc_pkg::Cp1Limit) begin
      enc[0] = lcp[7:0];
      enc_n  = 3'd1;
    end else if (lcp < utf8lc_pkg::Cp2Limit) begin
      enc[0] = utf8lc_pkg::Tag2 | {3'd0, lcp[10:6]};
      enc[1] = utf8lc_pkg::ContTag | {2'd0, lcp[5:0]};
      enc_n  = 3'd2;
    end else if (lcp < utf8lc_pkg::Cp3Limit) begin
      enc[0] = utf8lc_pkg::Tag3 | {4'd0, lcp[15:12]};
      enc[1] = utf8lc_pkg::ContTag | {2'd0, lcp[11:6]};
      enc[2] = utf8lc_pkg::ContTag | {2'd0, lcp[5:0]};
      enc_n  = 3'd3;
    end else if (lcp < utf8lc_pkg::CpLimit) begin
      enc[0] = utf8lc_pkg::Tag4 | {5'd0, lcp[20:18]};
      enc[1] = utf8lc_pkg::ContTag | {2'd0, lcp[17:12]};
      enc[2] = utf8lc_pkg::ContTag | {2'd0, lcp[11:6]};
      enc[3] = utf8lc_pkg::ContTag | {2'd0, lcp[5:0]};
      enc_n  = 3'd4;
    end else begin
      enc_n  = 3'd0;
    end
  end

  // sequence tracking; raw output is held[0..raw_h-1] then an optional tail byte
  always_comb begin
    held_nxt     = held;
    held_cnt_nxt = held_cnt;
    use_enc      = 1'b0;
    raw_h        = 2'd0;
    tail         = b;
    tail_en      = 1'b0;
    if (held_cnt != 2'd0 && is_cont) begin
      if (complete) begin
        use_enc      = 1'b1;
        held_cnt_nxt = 2'd0;
      end else begin
        held_nxt[held_cnt] = b;
        held_cnt_nxt       = held_cnt + 2'd1;
        if (beat.in_last) begin
          // cut off at end of string
          raw_h        = held_cnt;
          tail_en      = 1'b1;
          held_cnt_nxt = 2'd0;
        end
      end
    end else begin
      raw_h        = held_cnt;  // broken sequence flushes first
      held_cnt_nxt = 2'd0;
      if (!b[7]) begin
        tail    = asc_low[7:0];
        tail_en = 1'b1;
      end else if (is_lead) begin
        held_nxt[0] = b;
        if (beat.in_last) begin
          tail_en = 1'b1;
        end else begin
          held_cnt_nxt = 2'd1;
        end
      end else begin
        tail_en = 1'b1;  // stray byte
      end
    end
  end

  // result group
  always_comb begin
    grp = '0;
    if (use_enc) begin
      grp.bytes = enc;
      cnt       = enc_n;
    end else begin
      for (int k = 0; k < utf8lc_pkg::HeldDepth; k++) begin
        grp.bytes[k] = (k < int'(raw_h)) ? held[k] : tail;
      end
      grp.bytes[utf8lc_pkg::MaxOut-1] = tail;
      cnt = {1'b0, raw_h} + {2'd0, tail_en};
    end
    grp.marker = (cnt == 3'd0);
    grp.cnt    = grp.marker ? 3'd1 : cnt;
    grp.last   = beat.in_last;
  end

  assign grp_load = (cnt != 3'd0) || beat.in_last;

endmodule

FILE: design/utf8_lowercase_transcoder_top.sv
// utf8_lowercase_transcoder_top: utf8 byte stream lowercaser, top level
// holds the open-sequence registers and the output group register
// depends on utf8lc_pkg and utf8lc_step
//
// usage
// - input channel in_valid/in_ready/in_data: one beat per raw byte of the
//   string, in_last set on the final byte of the string
// - output channel out_valid/out_ready/out_data: one beat per emitted byte;
//   run_end marks the last beat caused by an input beat, string_end the last
//   beat of the string; a final input byte that produces nothing gives one
//   end-marker beat with byte_present low and out_byte zero
// - an input byte produces 0 to 4 output beats; a byte that only extends an
//   open multi-byte sequence produces none
// - latency: the first beat of a byte's group is presented the cycle after
//   the byte is accepted
// - throughput: one input byte per cycle while each byte yields at most one
//   output beat and the receiver takes every beat; a longer group holds the
//   output register, and the following input byte waits, until its last beat is taken
// - the output register takes a new group in the same cycle its last beat is
//   taken, so the two sides overlap with no bubble
// - receiver stall: the current beat holds and in_ready drops until the last
//   beat of the group in flight is taken
// - reset: discards any open sequence and any untaken output beats; no
//   clearing pass, in_ready is high the first cycle out of reset
module utf8_lowercase_transcoder_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  utf8lc_pkg::in_beat_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output utf8lc_pkg::out_beat_t out_data
);

  // open sequence: lead byte and continuation bytes seen so far
  utf8lc_pkg::held_bytes_t held_r;
  utf8lc_pkg::held_bytes_t held_nxt;
  utf8lc_pkg::held_t       held_cnt_r;
  utf8lc_pkg::held_t       held_cnt_nxt;

  // output group register, drained one beat per cycle from byte 0 while out_ready is high
  utf8lc_pkg::out_bytes_t  bytes_r;
  utf8lc_pkg::cnt_t        rem_r;
  logic                    marker_r;
  logic                    last_r;

  utf8lc_pkg::grp_t        grp;
  logic                    grp_load;
  logic                    in_fire;
  logic                    out_fire;

  utf8lc_step u_step (
    .beat         (in_data),
    .held         (held_r),
    .held_cnt     (held_cnt_r),
    .grp          (grp),
    .grp_load     (grp_load),
    .held_nxt     (held_nxt),
    .held_cnt_nxt (held_cnt_nxt)
  );

  // accept when the group register is empty or its final beat leaves now
  assign in_ready  = (rem_r == 3'd0) || (out_ready && rem_r == 3'd1);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (rem_r != 3'd0);
  assign out_fire  = out_valid && out_ready;

  assign out_data.out_byte     = marker_r ? 8'h00 : bytes_r[0];
  assign out_data.byte_present = !marker_r;
  assign out_data.run_end      = (rem_r == 3'd1);
  assign out_data.string_end   = (rem_r == 3'd1) && last_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      rem_r      <= 3'd0;
      marker_r   <= 1'b0;
      last_r     <= 1'b0;
    end else begin
      if (in_fire) begin
        held_cnt_r <= held_cnt_nxt;
      end
      if (in_fire && grp_load) begin
        rem_r    <= grp.cnt;
        marker_r <= grp.marker;
        last_r   <= grp.last;
      end else if (out_fire) begin
        rem_r <= rem_r - 3'd1;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_r <= held_nxt;
    end
    if (in_fire && grp_load) begin
      bytes_r <= grp.bytes;
    end else if (out_fire) begin
      bytes_r <= {8'h00, bytes_r[utf8lc_pkg::MaxOut-1:1]};
    end
  end

  // an open sequence always starts with a valid lead byte
  assert property (@(posedge clk) disable iff (!rst_n)
    held_cnt_r != 2'd0 |->
      (held_r[0] >= utf8lc_pkg::LeadMin && held_r[0] <= utf8lc_pkg::LeadMax))
    else $error("open sequence without a lead byte");

  // the end of a string leaves no open sequence behind
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.in_last |=> held_cnt_r == 2'd0)
    else $error("bytes still held after the last byte of a string");

  // an end marker is always a lone beat that closes the string
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.byte_present |-> out_data.run_end && out_data.string_end)
    else $error("end marker not alone at the end of a string");

  // a byte that opens a sequence while none is open, or extends one, with more to come emits nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_data.in_last && held_cnt_nxt > held_cnt_r |-> !grp_load)
    else $error("output produced while a sequence stays open");

endmodule
